>>> src/bitvector_rank_select_unit_assert.svh
// assertion macros for the rank/select unit
`ifndef BITVECTOR_RANK_SELECT_UNIT_ASSERT_SVH
`define BITVECTOR_RANK_SELECT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define BRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/brs_pkg.sv
// ---------------------------------------------------------------------------
// brs_pkg
// Shared constants, types and helpers of the rank/select bit vector unit.
// ---------------------------------------------------------------------------
`default_nettype none
package brs_pkg;
	localparam int unsigned TOTAL_BITS_DEF = 65536;
	localparam int unsigned SB_BITS_DEF    = 1024;

	localparam logic [3:0] FN_GET    = 4'd0;
	localparam logic [3:0] FN_SET    = 4'd1;
	localparam logic [3:0] FN_CLR    = 4'd2;
	localparam logic [3:0] FN_GGET   = 4'd3;
	localparam logic [3:0] FN_GSET   = 4'd4;
	localparam logic [3:0] FN_GCLR   = 4'd5;
	localparam logic [3:0] FN_RANK   = 4'd6;
	localparam logic [3:0] FN_SELECT = 4'd7;
	localparam logic [3:0] FN_POP    = 4'd8;

	typedef struct packed {
		logic [3:0]  func;
		logic [15:0] position;
		logic [63:0] group_value;
		logic [6:0]  group_width;
		logic [31:0] target_count;
	} req_t;

	typedef struct packed {
		logic [32:0] result_value;
		logic        not_found;
	} rsp_t;

	// population count of one word
	function automatic logic [6:0] pop64(input logic [63:0] x);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < 64; i++) c = c + 7'(x[i]);
		return c;
	endfunction

	// low mask of a given width, widths above 64 saturate
	function automatic logic [63:0] low_mask(input logic [6:0] w);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 64; i++) m[i] = (7'(i) < w);
		return m;
	endfunction

	// mask of bits 0..sh inclusive
	function automatic logic [63:0] upto_mask(input logic [5:0] sh);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 64; i++) m[i] = (6'(i) <= sh);
		return m;
	endfunction
endpackage
`default_nettype wire

>>> src/brs_chan_if.sv
// ---------------------------------------------------------------------------
// brs_chan_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
`default_nettype none
interface brs_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/bitvector_rank_select_unit.sv
// Bit and group ops read their word, then answer or write it back; unused codes are
// answered from dispatch. Rank and popcount add superblock and block counts, then sum
// words; select then probes superblocks, blocks and words and scans the chosen word
// bit by bit. After a bit change the next rank/select/popcount first rebuilds counters
// from the dirty superblock to the end. One transaction at a time; after reset a sweep
// clears all words and counters.
// ---------------------------------------------------------------------------
// bitvector_rank_select_unit
// Bit vector with superblock/block counters answering rank and select.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitvector_rank_select_unit_assert.svh"
module bitvector_rank_select_unit #(
	parameter int unsigned TOTAL_BITS = brs_pkg::TOTAL_BITS_DEF,
	parameter int unsigned SB_BITS    = brs_pkg::SB_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	brs_chan_if.sink   in_ch,
	brs_chan_if.source out_ch,
	brs_chan_if.sink   cfg_ch
);
	localparam int unsigned NUM_SB   = (TOTAL_BITS + SB_BITS - 1) / SB_BITS;
	localparam int unsigned SB_WORDS = SB_BITS / 64;
	localparam int unsigned BLK_W    = SB_BITS / 256;
	localparam int unsigned NUM_WORDS = NUM_SB * SB_WORDS;
	localparam int unsigned WAW = $clog2(NUM_WORDS);
	localparam int unsigned SAW = (NUM_SB > 1) ? $clog2(NUM_SB) : 1;
	localparam int unsigned BWW = (BLK_W > 1) ? $clog2(BLK_W) : 1;
	localparam int unsigned PW  = ($clog2(TOTAL_BITS) > 16) ? $clog2(TOTAL_BITS) : 16;
	localparam int unsigned DW  = PW + 1;
	localparam logic [32:0] TOT33 = 33'(TOTAL_BITS);

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_WRD    = 4'd2;
	localparam logic [3:0] ST_WMOD   = 4'd3;
	localparam logic [3:0] ST_RB_RD  = 4'd4;
	localparam logic [3:0] ST_RB_ACC = 4'd5;
	localparam logic [3:0] ST_RK_SB  = 4'd6;
	localparam logic [3:0] ST_RK_W   = 4'd7;
	localparam logic [3:0] ST_RK_FIN = 4'd8;
	localparam logic [3:0] ST_SL_SB  = 4'd9;
	localparam logic [3:0] ST_SL_BK  = 4'd10;
	localparam logic [3:0] ST_SL_W   = 4'd11;
	localparam logic [3:0] ST_SL_BIT = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;
	localparam logic [3:0] ST_DISP   = 4'd14;

	// memories
	logic [63:0] words_mem [NUM_WORDS];
	logic [31:0] sbc_mem [NUM_SB];
	logic [32:0] blk_mem [NUM_SB];

	logic [3:0]       st_q;
	brs_pkg::req_t    req_q;
	logic [31:0]      base_q;
	logic [DW-1:0]    dirty_q;
	logic [WAW-1:0]   waddr_q;
	logic [WAW:0]     wcnt_q;
	logic [63:0]      wrd_q;
	logic [31:0]      sbrd_q;
	logic [32:0]      bkrd_q;
	logic             rd_pend_q;
	logic [SAW:0]     s_q;
	logic [1:0]       b_q;
	logic [BWW:0]     i_q;
	logic [32:0]      acc_q;
	logic [32:0]      run_q;
	logic [10:0]      bc_q;
	logic [32:0]      blk_pack_q;
	logic [32:0]      cnt_q;
	logic [32:0]      total_q;
	logic [WAW-1:0]   last_q;
	logic [5:0]       bit_q;
	brs_pkg::rsp_t    rsp_q;
	logic             ov_q;
	logic             wr_q;
	logic [63:0]      wdat_q;
	logic             sbw_q;
	logic [SAW-1:0]   sbwa_q;
	logic [31:0]      sbwd_q;
	logic [32:0]      bkwd_q;
	logic [SAW-1:0]   sra_q;

	// word memory, one port
	always_ff @(posedge clk) begin
		if (wr_q) words_mem[waddr_q] <= wdat_q;
		wrd_q <= words_mem[waddr_q];
	end

	// counter memories
	always_ff @(posedge clk) begin
		if (sbw_q) begin
			sbc_mem[sbwa_q] <= sbwd_q;
			blk_mem[sbwa_q] <= bkwd_q;
		end
		sbrd_q <= sbc_mem[sra_q];
		bkrd_q <= blk_mem[sra_q];
	end

	wire in_inside = 32'(req_q.position) < TOTAL_BITS;
	wire is_rank = (req_q.func == brs_pkg::FN_RANK);
	wire is_sel = (req_q.func == brs_pkg::FN_SELECT);
	wire [5:0] sh = req_q.position[5:0];
	wire [WAW-1:0] pos_w = WAW'(req_q.position >> 6);
	wire [63:0] gmask = brs_pkg::low_mask(req_q.group_width);
	wire is_set = (req_q.func == brs_pkg::FN_SET) || (req_q.func == brs_pkg::FN_GSET);
	wire [63:0] bits = ((req_q.func == brs_pkg::FN_SET) || (req_q.func == brs_pkg::FN_CLR))
		? (64'd1 << sh) : ((req_q.group_value & gmask) << sh);
	wire [6:0] wpop = brs_pkg::pop64(wrd_q);
	// rank position; select and popcount count up to the last position
	wire [PW-1:0] rk_pos = (is_rank && in_inside) ? PW'(req_q.position)
		: PW'(TOTAL_BITS - 1);
	wire [SAW-1:0] rk_sb = SAW'(32'(rk_pos) / SB_BITS);
	wire [1:0] rk_blk = 2'((32'(rk_pos) % SB_BITS) / (SB_BITS / 4));
	wire [10:0] bk_f [3];
	assign bk_f[0] = bkrd_q[10:0];
	assign bk_f[1] = bkrd_q[21:11];
	assign bk_f[2] = bkrd_q[32:22];
	wire [12:0] bk_sum = (rk_blk > 2'd0 ? 13'(bk_f[0]) : 13'd0)
		+ (rk_blk > 2'd1 ? 13'(bk_f[1]) : 13'd0)
		+ (rk_blk > 2'd2 ? 13'(bk_f[2]) : 13'd0);
	wire [WAW-1:0] rk_w0 = WAW'(32'(rk_sb) * SB_WORDS + 32'(rk_blk) * BLK_W);

	assign in_ch.ready = (st_q == ST_IDLE) && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.data = rsp_q;
	assign cfg_ch.ready = 1'b1;

	// base count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_ch.valid) base_q <= cfg_ch.data;
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			dirty_q <= DW'(TOTAL_BITS);
			waddr_q <= '0;
			sra_q <= '0;
			wr_q <= 1'b0;
			sbw_q <= 1'b0;
			ov_q <= 1'b0;
			rd_pend_q <= 1'b0;
			wcnt_q <= '0;
		end else begin
			wr_q <= 1'b0;
			sbw_q <= 1'b0;
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					// sweep words and counters to zero
					if (wcnt_q == (WAW+1)'(NUM_WORDS)) begin
						st_q <= ST_IDLE;
					end else begin
						wr_q <= 1'b1;
						wdat_q <= '0;
						waddr_q <= WAW'(wcnt_q);
						sbw_q <= (wcnt_q < (WAW+1)'(NUM_SB));
						sbwa_q <= SAW'(wcnt_q);
						sbwd_q <= '0;
						bkwd_q <= '0;
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_ch.valid && !ov_q) begin
						req_q <= in_ch.data;
						st_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					rsp_q <= '0;
					case (req_q.func)
						brs_pkg::FN_GET, brs_pkg::FN_GGET, brs_pkg::FN_SET,
						brs_pkg::FN_CLR, brs_pkg::FN_GSET, brs_pkg::FN_GCLR: begin
							if (in_inside) begin
								waddr_q <= pos_w;
								rd_pend_q <= 1'b1;
								st_q <= ST_WRD;
							end else begin
								ov_q <= 1'b1;
								st_q <= ST_IDLE;
							end
						end
						brs_pkg::FN_RANK, brs_pkg::FN_SELECT, brs_pkg::FN_POP: begin
							if (dirty_q < DW'(TOTAL_BITS)) begin
								s_q <= (SAW+1)'(32'(dirty_q) / SB_BITS);
								sra_q <= SAW'(32'(dirty_q) / SB_BITS);
								waddr_q <= WAW'((32'(dirty_q) / SB_BITS) * SB_WORDS);
								b_q <= '0;
								i_q <= '0;
								bc_q <= '0;
								blk_pack_q <= '0;
								rd_pend_q <= 1'b1;
								st_q <= ST_RB_RD;
							end else begin
								// counters clean: rank at the position, or of the last position for select and popcount
								sra_q <= rk_sb;
								st_q <= ST_RK_SB;
								rd_pend_q <= 1'b1;
							end
						end
						default: begin
							ov_q <= 1'b1;
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_WRD: begin
					// wait for the registered read data
					if (rd_pend_q) rd_pend_q <= 1'b0;
					else st_q <= ST_WMOD;
				end
				ST_WMOD: begin
					if (req_q.func == brs_pkg::FN_GET) begin
						rsp_q.result_value <= 33'(wrd_q[sh]);
						ov_q <= 1'b1;
					end else if (req_q.func == brs_pkg::FN_GGET) begin
						rsp_q.result_value <= 33'((wrd_q >> sh) & gmask);
						ov_q <= 1'b1;
					end else begin
						wr_q <= 1'b1;
						wdat_q <= is_set ? (wrd_q | bits) : (wrd_q & ~bits);
						if ((is_set ? ((wrd_q & bits) != bits) : ((wrd_q & bits) != 64'd0))
							&& (DW'(req_q.position) < dirty_q))
							dirty_q <= DW'(req_q.position);
						ov_q <= 1'b1;
					end
					st_q <= ST_IDLE;
				end
				ST_RB_RD: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						// first word of the rebuild: take running count base from superblock
						if (waddr_q == WAW'(32'(s_q) * SB_WORDS) && b_q == 2'd0 && i_q == '0
							&& 32'(s_q) == 32'(dirty_q) / SB_BITS)
							run_q <= 33'(sbrd_q);
						st_q <= ST_RB_ACC;
					end
				end
				ST_RB_ACC: begin
					logic [10:0] c;
					logic [32:0] pk;
					c = bc_q + 11'(wpop);
					pk = blk_pack_q;
					run_q <= run_q + 33'(wpop);
					if (i_q == (BWW+1)'(BLK_W - 1)) begin
						i_q <= '0;
						bc_q <= '0;
						if (b_q < 2'd3) pk[11*b_q +: 11] = c;
						b_q <= b_q + 2'd1;
						if (b_q == 2'd3) begin
							sbw_q <= 1'b1;
							sbwa_q <= SAW'(s_q);
							bkwd_q <= pk;
							blk_pack_q <= '0;
						end else begin
							blk_pack_q <= pk;
						end
					end else begin
						i_q <= i_q + 1'b1;
						bc_q <= c;
					end
					// superblock start value captured before its words are summed
					if (waddr_q == WAW'(32'(s_q) * SB_WORDS)) sbwd_q <= run_q[31:0];
					if (32'(waddr_q) == NUM_WORDS - 1) begin
						dirty_q <= DW'(TOTAL_BITS);
						sra_q <= rk_sb;
						rd_pend_q <= 1'b1;
						st_q <= ST_RK_SB;
					end else begin
						waddr_q <= waddr_q + 1'b1;
						if (i_q == (BWW+1)'(BLK_W - 1) && b_q == 2'd3) s_q <= s_q + 1'b1;
						st_q <= ST_RB_RD;
					end
				end
				ST_RK_SB: begin
					if (rd_pend_q) begin
						// hold the read while the last counter write lands
						if (!sbw_q) rd_pend_q <= 1'b0;
					end else begin
						acc_q <= 33'(sbrd_q) + 33'(bk_sum);
						waddr_q <= rk_w0;
						last_q <= WAW'(rk_pos >> 6);
						rd_pend_q <= 1'b1;
						st_q <= ST_RK_W;
					end
				end
				ST_RK_W: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (waddr_q == last_q) begin
						logic [63:0] m;
						m = is_rank ? brs_pkg::upto_mask(rk_pos[5:0]) : '1;
						total_q <= acc_q + 33'(brs_pkg::pop64(wrd_q & m));
						st_q <= ST_RK_FIN;
					end else begin
						acc_q <= acc_q + 33'(wpop);
						waddr_q <= waddr_q + 1'b1;
						rd_pend_q <= 1'b1;
					end
				end
				ST_RK_FIN: begin
					if (!is_sel) begin
						rsp_q.result_value <= 33'(base_q) + total_q;
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (req_q.target_count <= base_q
						|| 33'(req_q.target_count - base_q) > total_q) begin
						rsp_q.result_value <= TOT33;
						rsp_q.not_found <= 1'b1;
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						cnt_q <= 33'(req_q.target_count - base_q);
						s_q <= '0;
						sra_q <= SAW'(1 % NUM_SB);
						rd_pend_q <= 1'b1;
						st_q <= ST_SL_SB;
					end
				end
				ST_SL_SB: begin
					// linear walk over superblock starts
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (32'(s_q) + 1 < NUM_SB && 33'(sbrd_q) < cnt_q) begin
						s_q <= s_q + 1'b1;
						sra_q <= SAW'(s_q + 2);
						rd_pend_q <= 1'b1;
					end else begin
						sra_q <= SAW'(s_q);
						rd_pend_q <= 1'b1;
						b_q <= '0;
						i_q <= '0;
						st_q <= ST_SL_BK;
					end
				end
				ST_SL_BK: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						cnt_q <= cnt_q;
					end else if (b_q == 2'd0 && i_q != (BWW+1)'(1)) begin
						cnt_q <= cnt_q - 33'(sbrd_q);
						i_q <= (BWW+1)'(1);
					end else if (b_q < 2'd3 && cnt_q > 33'(bk_f[b_q])) begin
						cnt_q <= cnt_q - 33'(bk_f[b_q]);
						b_q <= b_q + 2'd1;
					end else begin
						i_q <= '0;
						waddr_q <= WAW'(32'(s_q) * SB_WORDS + 32'(b_q) * BLK_W);
						rd_pend_q <= 1'b1;
						st_q <= ST_SL_W;
					end
				end
				ST_SL_W: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (32'(waddr_q) + 1 < NUM_WORDS && 33'(wpop) < cnt_q) begin
						cnt_q <= cnt_q - 33'(wpop);
						waddr_q <= waddr_q + 1'b1;
						rd_pend_q <= 1'b1;
					end else begin
						bit_q <= '0;
						st_q <= ST_SL_BIT;
					end
				end
				ST_SL_BIT: begin
					// one bit a cycle within the chosen word
					if (wrd_q[bit_q] && cnt_q == 33'd1) begin
						rsp_q.result_value <= 33'({waddr_q, bit_q});
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (bit_q == 6'd63) begin
						rsp_q.result_value <= TOT33;
						rsp_q.not_found <= 1'b1;
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						if (wrd_q[bit_q]) cnt_q <= cnt_q - 33'd1;
						bit_q <= bit_q + 6'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// handshake and result checks
	`BRS_ASSERT_IMP(a_no_in_busy, clk, arst_n, st_q != ST_IDLE, !in_ch.ready)
	`BRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`BRS_ASSERT_IMP(a_nf_sel, clk, arst_n, out_ch.valid && out_ch.data.not_found,
		out_ch.data.result_value == TOT33)
endmodule
`default_nettype wire

>>> bench/bitvector_rank_select_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitvector_rank_select_unit_tb
// Drives bit, group, rank, select and popcount transactions into the unit
// under several base_count settings, predicts every result from a flat copy
// of the bit vector and compares each result in order, field by field.
// ---------------------------------------------------------------------------
`default_nettype none

// expected results for the rank/select unit, predicted from a flat bit copy
class rank_select_scoreboard;
	logic [63:0] vec_words [1024];
	logic [31:0] base_ones;
	brs_pkg::rsp_t pending [$];
	int errors;
	int results_seen;
	int misses;

	function new();
		foreach (vec_words[i]) vec_words[i] = '0;
		base_ones = '0;
		errors = 0;
		results_seen = 0;
		misses = 0;
	endfunction

	function void set_base(logic [31:0] v);
		base_ones = v;
	endfunction

	// ones in positions 0..pos inclusive
	function logic [32:0] ones_through(int unsigned pos);
		logic [32:0] acc;
		int unsigned last;
		int unsigned sh;
		acc = '0;
		last = pos / 64;
		sh = pos % 64;
		for (int unsigned w = 0; w < last; w++) acc += $countones(vec_words[w]);
		if (sh == 63) acc += $countones(vec_words[last]);
		else acc += $countones(vec_words[last] & ((64'd1 << (sh + 1)) - 64'd1));
		return acc;
	endfunction

	// accepted input: update the bit copy and queue the expected result
	function void note_input(brs_pkg::req_t r);
		brs_pkg::rsp_t exp_rsp;
		int unsigned wi;
		int unsigned sh;
		logic [63:0] gmask;
		logic [63:0] bits;
		logic [32:0] total;
		longint cnt;
		int unsigned c;
		wi = r.position / 64;
		sh = r.position % 64;
		gmask = (r.group_width >= 64) ? '1 : ((64'd1 << r.group_width) - 64'd1);
		exp_rsp = '0;
		case (r.func)
			brs_pkg::FN_GET: exp_rsp.result_value = 33'((vec_words[wi] >> sh) & 64'd1);
			brs_pkg::FN_GGET: exp_rsp.result_value = 33'((vec_words[wi] >> sh) & gmask);
			brs_pkg::FN_SET, brs_pkg::FN_CLR, brs_pkg::FN_GSET, brs_pkg::FN_GCLR: begin
				if (r.func == brs_pkg::FN_SET || r.func == brs_pkg::FN_CLR) bits = 64'd1 << sh;
				else bits = (r.group_value & gmask) << sh;
				if (r.func == brs_pkg::FN_SET || r.func == brs_pkg::FN_GSET)
					vec_words[wi] |= bits;
				else
					vec_words[wi] &= ~bits;
			end
			brs_pkg::FN_RANK:
				exp_rsp.result_value = 33'(base_ones) + ones_through(r.position);
			brs_pkg::FN_POP:
				exp_rsp.result_value = 33'(base_ones) + ones_through(65535);
			brs_pkg::FN_SELECT: begin
				total = ones_through(65535);
				cnt = longint'(r.target_count) - longint'(base_ones);
				if (cnt <= 0 || cnt > longint'(total)) begin
					exp_rsp.not_found = 1'b1;
					exp_rsp.result_value = 33'd65536;
				end else begin
					// walk words, then bits, until the target one is reached
					for (int unsigned w = 0; w < 1024; w++) begin
						c = $countones(vec_words[w]);
						if (longint'(c) < cnt) cnt -= c;
						else begin
							for (int unsigned b = 0; b < 64; b++) begin
								if (vec_words[w][b]) begin
									cnt--;
									if (cnt == 0) begin
										exp_rsp.result_value = 33'(w * 64 + b);
										break;
									end
								end
							end
							break;
						end
					end
				end
			end
			default: ;
		endcase
		pending.push_back(exp_rsp);
	endfunction

	// accepted result: compare against the oldest expectation
	function void check_result(brs_pkg::rsp_t got);
		brs_pkg::rsp_t exp_rsp;
		results_seen++;
		if (pending.size() == 0) begin
			$error("result with nothing expected: result_value %0d not_found %0d",
				got.result_value, got.not_found);
			errors++;
			return;
		end
		exp_rsp = pending.pop_front();
		if (exp_rsp.not_found) misses++;
		if (got.result_value !== exp_rsp.result_value) begin
			$error("result_value: expected %0d, got %0d", exp_rsp.result_value,
				got.result_value);
			errors++;
		end
		if (got.not_found !== exp_rsp.not_found) begin
			$error("not_found: expected %0d, got %0d", exp_rsp.not_found, got.not_found);
			errors++;
		end
	endfunction
endclass

module bitvector_rank_select_unit_tb;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1930;

	logic clk;
	logic arst_n;
	logic quiet_run;
	int idle_cycles;
	int items_sent;

	brs_chan_if #(.T(brs_pkg::req_t)) in_ch ();
	brs_chan_if #(.T(brs_pkg::rsp_t)) out_ch ();
	brs_chan_if #(.T(logic [31:0])) cfg_ch ();

	rank_select_scoreboard sb = new();

	bitvector_rank_select_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// input-side idle bursts
	task automatic maybe_gap();
		if (!quiet_run && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 13)) @(negedge clk);
	endtask

	// wait until every expected result has come back
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// one transaction on the request channel
	task automatic send_req(brs_pkg::req_t r);
		maybe_gap();
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.data = r;
		forever begin
			@(posedge clk);
			if (in_ch.ready) break;
		end
		sb.note_input(r);
		items_sent++;
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// base_count write while idle
	task automatic write_base(logic [31:0] v);
		drain();
		repeat (20) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = v;
		forever begin
			@(posedge clk);
			if (cfg_ch.ready) break;
		end
		sb.set_base(v);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic brs_pkg::req_t mk(logic [3:0] f, logic [15:0] p, logic [63:0] gv,
			logic [6:0] gw, logic [31:0] tc);
		brs_pkg::req_t r;
		r.func = f;
		r.position = p;
		r.group_value = gv;
		r.group_width = gw;
		r.target_count = tc;
		return r;
	endfunction

	// random item, mostly writes and queries that exercise counters
	function automatic brs_pkg::req_t random_req();
		brs_pkg::req_t r;
		int sel;
		logic [32:0] total;
		r.func = 4'($urandom_range(0, 8));
		sel = $urandom_range(0, 19);
		if (sel == 0) r.func = 4'($urandom_range(9, 15));
		else if (sel < 6) r.func = brs_pkg::FN_GSET;
		r.position = ($urandom_range(0, 2) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 4095));
		r.group_value = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: r.group_width = 7'($urandom);
			1: r.group_width = 7'd64;
			default: r.group_width = 7'($urandom_range(1, 64));
		endcase
		total = sb.ones_through(65535);
		case ($urandom_range(0, 3))
			0: r.target_count = $urandom;
			1: r.target_count = sb.base_ones + 32'($urandom_range(0, 3));
			default: r.target_count = sb.base_ones
				+ 32'($urandom_range(1, int'(total) + 2));
		endcase
		return r;
	endfunction

	// output-side stall bursts
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_run && $urandom_range(0, 2) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [31:0] bases [4];
		idle_cycles = 0;
		items_sent = 0;
		quiet_run = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every func, empty and oversize groups, misses
		send_req(mk(brs_pkg::FN_POP, 16'd0, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_SELECT, 16'd0, '0, 7'd1, 32'd1));
		send_req(mk(brs_pkg::FN_SET, 16'd0, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_SET, 16'hFFFF, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_SET, 16'hFFFF, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_GET, 16'hFFFF, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_GSET, 16'd100, '1, 7'd64, 32'd0));
		send_req(mk(brs_pkg::FN_GSET, 16'd200, '1, 7'd127, 32'd0));
		send_req(mk(brs_pkg::FN_GSET, 16'd300, '1, 7'd0, 32'd0));
		send_req(mk(brs_pkg::FN_GGET, 16'd64, '0, 7'd100, 32'd0));
		send_req(mk(brs_pkg::FN_GGET, 16'd300, '0, 7'd0, 32'd0));
		send_req(mk(brs_pkg::FN_RANK, 16'hFFFF, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_RANK, 16'd127, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_SELECT, 16'd0, '0, 7'd1, 32'd60));
		send_req(mk(brs_pkg::FN_SELECT, 16'd0, '0, 7'd1, 32'hFFFFFFFF));
		send_req(mk(brs_pkg::FN_SELECT, 16'd0, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_CLR, 16'd0, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_CLR, 16'd0, '0, 7'd1, 32'd0));
		send_req(mk(brs_pkg::FN_GCLR, 16'd130, 64'hF0F0, 7'd16, 32'd0));
		send_req(mk(4'd9, 16'd5, '1, 7'd3, 32'd7));
		send_req(mk(4'd15, 16'hFFFF, '1, 7'd127, 32'hFFFFFFFF));
		send_req(mk(brs_pkg::FN_POP, 16'd0, '0, 7'd1, 32'd0));

		// random phases under different base counts, the last without idling
		bases[0] = 32'hFFFFFFFF;
		bases[1] = $urandom;
		bases[2] = 32'd1;
		bases[3] = 32'd0;
		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph]);
			if (ph == 1) begin
				send_req(mk(brs_pkg::FN_SELECT, 16'd0, '0, 7'd1, bases[ph]));
				send_req(mk(brs_pkg::FN_RANK, 16'd0, '0, 7'd1, 32'd0));
			end
			if (ph == 3) quiet_run = 1'b1;
			repeat (RANDOM_ITEMS / 4) send_req(random_req());
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d transactions, %0d results checked, %0d select misses",
			items_sent, sb.results_seen, sb.misses);
		$display("base_count settings: 0, all ones, one, random; final popcount %0d",
			sb.ones_through(65535));
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

`default_nettype wire
